>>> rtl/core/ctag_pkg.sv
package ctag_pkg;

  localparam int SET_BITS = 12;
  localparam int WAYS = 4;
  localparam int ADDRESS_BITS = 32;

  localparam int SET_W = SET_BITS;
  localparam int TAG_W = ADDRESS_BITS;
  localparam int WAY_W = 2;
  localparam int OP_W = 2;
  localparam int RAM_AW = SET_BITS + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int IB_W = $clog2(SET_BITS + 1) > 4 ? $clog2(SET_BITS + 1) : 4;
  localparam int SH_W = IB_W + 1;

  localparam int PADDR_W = 4;
  localparam int IN_TDATA_W = ((OP_W + ADDRESS_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_FETCH = 2'd2;

  localparam logic [1:0] REG_SPLIT_MODE = 2'd0;
  localparam logic [1:0] REG_FOUR_WAY = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd2;
  localparam logic [1:0] REG_INDEX_BITS = 2'd3;

  typedef struct packed {
    logic valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [WAY_W-1:0] ptr;
    entry_t [WAYS-1:0] ways;
  } row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_full;
  } status_t;

endpackage

>>> rtl/core/ctag_ram.sv
module ctag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ctag_ctrl.sv
module ctag_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctag_pkg::status_t stat,
  output ctag_pkg::cmd_t    cmd
);
  import ctag_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_full) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_LOOKUP: begin
        cmd.rd = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = !stat.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOOKUP))
    else $error("accepted transaction did not start a lookup");

endmodule

>>> rtl/core/ctag_dp.sv
module ctag_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ctag_pkg::cmd_t                      cmd,
  output ctag_pkg::status_t                   stat,
  input  logic                                split_mode,
  input  logic                                four_way,
  input  logic [3:0]                          offset_bits,
  input  logic [3:0]                          index_bits,
  input  logic [ctag_pkg::OP_W-1:0]           op,
  input  logic [ctag_pkg::ADDRESS_BITS-1:0]   address,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                hit,
  output logic [ctag_pkg::WAY_W-1:0]          way,
  output logic                                instr_side
);
  import ctag_pkg::*;

  logic [RAM_AW-1:0]       clr_cnt;
  logic [OP_W-1:0]         op_q;
  logic [ADDRESS_BITS-1:0] address_q;
  logic [TAG_W-1:0]        tag_q;
  logic [SET_W-1:0]        set_q;
  logic                    instr_q;

  logic [IB_W-1:0]         ib;
  logic [SET_W:0]          set_mask;
  logic [ADDRESS_BITS-1:0] shifted;
  logic [SET_W-1:0]        set_v;
  logic [SH_W-1:0]         tag_sh;
  logic [TAG_W-1:0]        tag_v;
  logic                    instr_v;

  logic [$bits(row_t)-1:0] rdata;
  row_t                    row;
  row_t                    row_new;
  logic [WAYS-1:0]         match;
  logic                    hit_v;
  logic [WAY_W-1:0]        way_v;
  logic                    ram_we;
  logic [RAM_AW-1:0]       ram_waddr;
  logic [$bits(row_t)-1:0] ram_wdata;

  // address split
  always_comb begin
    ib = ({1'b0, index_bits} > IB_W'(SET_BITS)) ? IB_W'(SET_BITS) : IB_W'(index_bits);
    set_mask = ((SET_W + 1)'(1) << ib) - (SET_W + 1)'(1);
    shifted = address_q >> offset_bits;
    set_v = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    tag_sh = SH_W'(offset_bits) + SH_W'(ib);
    tag_v = TAG_W'(address_q >> tag_sh);
    instr_v = split_mode && (op_q == OP_FETCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + RAM_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q <= op;
      address_q <= address;
    end
    if (cmd.rd) begin
      tag_q <= tag_v;
      set_q <= set_v;
      instr_q <= instr_v;
    end
  end

  ctag_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr({instr_v, set_v}),
    .rdata(rdata)
  );

  // compare and replace
  always_comb begin
    row = row_t'(rdata);
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row.ways[w].valid && (row.ways[w].tag == tag_q) && (four_way || w == 0);
    end
    hit_v = |match;
    way_v = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) way_v = WAY_W'(w);
    end
    row_new = row;
    if (!hit_v) begin
      if (four_way) begin
        way_v = row.ptr;
        row_new.ptr = row.ptr + WAY_W'(1);
      end
      row_new.ways[way_v].valid = 1'b1;
      row_new.ways[way_v].tag = tag_q;
    end
  end

  always_comb begin
    ram_we = cmd.clr || (cmd.commit && !hit_v);
    ram_waddr = cmd.clr ? clr_cnt : {instr_q, set_q};
    ram_wdata = cmd.clr ? '0 : row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= hit_v;
      way <= way_v;
      instr_side <= instr_q;
    end
  end

  always_comb begin
    stat.clr_last = (clr_cnt == RAM_AW'(RAM_DEPTH - 1));
    stat.out_full = out_valid && !out_ready;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> (!cmd.rd && !cmd.commit && !cmd.load_in))
    else $error("lookup activity during clearing pass");

endmodule

>>> rtl/core/cache_tag_lookup_round_robin.sv
// set-associative tag directory with round-robin replacement
// input stream s_*: one lookup per transaction, tdata carries op and byte address
// output stream m_*: one result per lookup, tdata carries hit, way and side
// apb port: split_mode at 0x0, four_way at 0x4, offset_bits at 0x8, index_bits at 0xc
// each lookup runs through accept, set row read from the directory ram,
//   compare and read-modify-write of the row into the output register
// the next lookup is accepted in the cycle after the result is registered,
//   so no new lookup is taken until the previous one has been committed
// the result is held in an output register until taken; a new lookup may be
//   accepted and read meanwhile, and it waits at the compare step
// both directories share one ram, one row per set holding all ways and the
//   round-robin pointer, addressed by side and set
// after reset a clearing pass zeroes all 8192 rows, one per cycle; s_tready
//   stays low during it while configuration writes are still taken
// configuration must be written only with no lookup in flight; the block does not check
module cache_tag_lookup_round_robin (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ctag_pkg::IN_TDATA_W-1:0]      s_tdata,   // op, address, zero pad
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ctag_pkg::OUT_TDATA_W-1:0]     m_tdata,   // hit, way, instr_side, zero pad
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ctag_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import ctag_pkg::*;

  logic       split_mode;
  logic       four_way;
  logic [3:0] offset_bits;
  logic [3:0] index_bits;
  logic       cfg_we;
  logic [1:0] reg_idx;

  cmd_t       cmd;
  status_t    stat;
  logic       hit;
  logic [WAY_W-1:0] way;
  logic       instr_side;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode <= 1'b0;
      four_way <= 1'b0;
      offset_bits <= 4'd3;
      index_bits <= 4'd10;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SPLIT_MODE: split_mode <= pwdata[0];
        REG_FOUR_WAY: four_way <= pwdata[0];
        REG_OFFSET_BITS: offset_bits <= pwdata[3:0];
        REG_INDEX_BITS: index_bits <= pwdata[3:0];
        default: split_mode <= split_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPLIT_MODE: prdata = {31'd0, split_mode};
      REG_FOUR_WAY: prdata = {31'd0, four_way};
      REG_OFFSET_BITS: prdata = {28'd0, offset_bits};
      REG_INDEX_BITS: prdata = {28'd0, index_bits};
      default: prdata = '0;
    endcase
  end

  ctag_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ctag_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .split_mode (split_mode),
    .four_way   (four_way),
    .offset_bits(offset_bits),
    .index_bits (index_bits),
    .op         (s_tdata[OP_W-1:0]),
    .address    (s_tdata[OP_W +: ADDRESS_BITS]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .hit        (hit),
    .way        (way),
    .instr_side (instr_side)
  );

  assign m_tdata = {(OUT_TDATA_W - WAY_W - 2)'(0), instr_side, way, hit};

endmodule
